[hw/rtl/aks_pkg.sv]
// Package for the AES-128 key search checker: types, tables and round functions.
package aks_pkg;

  localparam int unsigned IdxW = 40;
  localparam int unsigned PrefixW = 25;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned NumRounds = 10;

  localparam logic [CfgIdxW-1:0] CFG_CT_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CT_LOW = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PREFIX = 2'd2;

  localparam logic [31:0] RANGE_LO = 32'h41414141;
  localparam logic [31:0] RANGE_HI = 32'h5a5a5a5a;
  localparam logic [31:0] TAG_HI = 32'h43727970;
  localparam logic [31:0] TAG_LO = 32'h546f6f6c;
  localparam logic [31:0] KEY_W2_FILL = 32'h7fffffff;
  localparam logic [31:0] KEY_W3 = 32'hffffffff;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [127:0]    key;
    logic [127:0]    st;
  } aks_item_t;

  localparam logic [7:0] RCON_TBL [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_rot_word(logic [31:0] w, logic [7:0] rcon);
    logic [31:0] r;
    r = {w[23:0], w[31:24]};
    return {SBOX[r[31:24]] ^ rcon, SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

  // Next round key, word 0 at the top.
  function automatic logic [127:0] key_fwd(logic [127:0] k, logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ sub_rot_word(k[31:0], rcon);
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // Previous round key; rcon is the one used to build k.
  function automatic logic [127:0] key_inv(logic [127:0] k, logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_rot_word(w3, rcon);
    return {w0, w1, w2, w3};
  endfunction

  // Byte n of the state sits at bits 127-8n downward; byte 4c+r is row r, column c.
  function automatic logic [127:0] inv_shift_sub(logic [127:0] s);
    logic [127:0] t;
    int unsigned src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + 4 - r) % 4) + r;
        t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = s[127 - 8 * (4 * c + r) -: 8];
        x2[r] = xtime(a[r]);
        x4[r] = xtime(x2[r]);
        x8[r] = xtime(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        // 14*a[r] ^ 11*a[r+1] ^ 13*a[r+2] ^ 9*a[r+3]
        t[127 - 8 * (4 * c + r) -: 8] =
            (x8[r] ^ x4[r] ^ x2[r]) ^
            (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4]) ^
            (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4]) ^
            (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
      end
    end
    return t;
  endfunction

endpackage

[hw/rtl/aks_key_stage.sv]
// One pipelined round of the forward key expansion.
module aks_key_stage #(
  parameter logic [7:0] Rcon = 8'h01
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  aks_pkg::aks_item_t item_i,
  input  logic [127:0]      ct_i,
  output logic              valid_o,
  output aks_pkg::aks_item_t item_o
);
  import aks_pkg::*;

  logic      valid_q;
  aks_item_t item_d, item_q;

  // st carries ct ^ key, which the last stage hands to the decrypt rounds
  always_comb begin
    item_d.idx = item_i.idx;
    item_d.key = key_fwd(item_i.key, Rcon);
    item_d.st  = ct_i ^ item_d.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/aks_dec_stage.sv]
// One pipelined inverse cipher round with on-the-fly inverse key schedule.
module aks_dec_stage #(
  parameter logic [7:0] Rcon = 8'h01,
  parameter bit         Last = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  aks_pkg::aks_item_t item_i,
  output logic              valid_o,
  output aks_pkg::aks_item_t item_o
);
  import aks_pkg::*;

  logic         valid_q;
  aks_item_t    item_d, item_q;
  logic [127:0] added;

  always_comb begin
    item_d.idx = item_i.idx;
    item_d.key = key_inv(item_i.key, Rcon);
    added      = inv_shift_sub(item_i.st) ^ item_d.key;
    item_d.st  = Last ? added : inv_mix(added);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/aes128_key_search_check.sv]
// Top level: AES-128 key candidate decrypt-and-check pipeline.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | candidate_index_i
//  out     | output    | out_valid_o / out_stall_i| echo_index_o, match_o, plain_*_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// 21 register stages: 10 key expansion rounds, 10 inverse rounds, one check/output stage.
// One item per cycle sustained while no stalled result holds the output; the whole pipeline advances together.
// A stalled result freezes every stage, so in_stall_o follows out_stall_i while out is full.
// Reset clears all valid bits and the configuration registers; cfg writes always complete.
module aes128_key_search_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [aks_pkg::IdxW-1:0]      candidate_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aks_pkg::IdxW-1:0]      echo_index_o,
  output logic                          match_o,
  output logic [63:0]                   plain_high_o,
  output logic [63:0]                   plain_low_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aks_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aks_pkg::CfgDataW-1:0]  cfg_data_i
);
  import aks_pkg::*;

  logic [63:0]        ct_high_q, ct_low_q;
  logic [PrefixW-1:0] prefix_q;
  logic               en;

  logic      key_valid [NumRounds+1];
  aks_item_t key_item  [NumRounds+1];
  logic      dec_valid [NumRounds+1];
  aks_item_t dec_item  [NumRounds+1];

  logic            out_valid_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_match_q, match_d;
  logic [127:0]    out_pt_q;
  logic [127:0]    pt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_high_q <= '0;
      ct_low_q  <= '0;
      prefix_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CT_HIGH: ct_high_q <= cfg_data_i;
        CFG_CT_LOW:  ct_low_q  <= cfg_data_i;
        CFG_PREFIX:  prefix_q  <= cfg_data_i[PrefixW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign key_valid[0]    = in_valid_i;
  assign key_item[0].idx = candidate_index_i;
  assign key_item[0].key = {prefix_q, candidate_index_i[39:33], candidate_index_i[32:1],
                            candidate_index_i[0], KEY_W2_FILL[30:0], KEY_W3};
  assign key_item[0].st  = '0;

  for (genvar k = 0; k < NumRounds; k++) begin : g_key
    aks_key_stage #(
      .Rcon (RCON_TBL[k])
    ) u_key (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (key_valid[k]),
      .item_i  (key_item[k]),
      .ct_i    ({ct_high_q, ct_low_q}),
      .valid_o (key_valid[k+1]),
      .item_o  (key_item[k+1])
    );
  end

  assign dec_valid[0] = key_valid[NumRounds];
  assign dec_item[0]  = key_item[NumRounds];

  // stage j undoes round 9-j and needs the rcon that built round key 10-j
  for (genvar j = 0; j < NumRounds; j++) begin : g_dec
    aks_dec_stage #(
      .Rcon (RCON_TBL[NumRounds-1-j]),
      .Last (j == NumRounds - 1)
    ) u_dec (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dec_valid[j]),
      .item_i  (dec_item[j]),
      .valid_o (dec_valid[j+1]),
      .item_o  (dec_item[j+1])
    );
  end

  assign pt = dec_item[NumRounds].st;

  always_comb begin
    match_d = (pt[127:96] >= RANGE_LO) && (pt[127:96] <= RANGE_HI) &&
              (pt[95:64] >= RANGE_LO) && (pt[95:64] <= RANGE_HI) &&
              (pt[63:32] == TAG_HI) && (pt[31:0] == TAG_LO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dec_valid[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q   <= dec_item[NumRounds].idx;
      out_match_q <= match_d;
      out_pt_q    <= pt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign echo_index_o = out_idx_q;
  assign match_o      = out_match_q;
  assign plain_high_o = out_pt_q[127:64];
  assign plain_low_o  = out_pt_q[63:0];

endmodule

[bench/aks_result_checker.sv]
// Result checker for the key search block: predicts each result and compares it.
module aks_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [aks_pkg::IdxW-1:0]     candidate_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [aks_pkg::IdxW-1:0]     echo_index_i,
  input  logic                         match_i,
  input  logic [63:0]                  plain_high_i,
  input  logic [63:0]                  plain_low_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [aks_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aks_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           match_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import aks_pkg::*;

  typedef struct {
    logic [IdxW-1:0] idx;
    logic            hit;
    logic [63:0]     ph;
    logic [63:0]     pl;
  } plain_result_t;

  typedef logic [43:0][31:0] key_sched_t;

  plain_result_t  pending_results[$];
  logic [63:0]    ct_high, ct_low;
  logic [PrefixW-1:0] key_prefix;
  logic [7:0]     inv_sub [256];

  initial begin
    ct_high = '0;
    ct_low = '0;
    key_prefix = '0;
    fail_count_o = 0;
    pending_o = 0;
    match_count_o = 0;
    for (int i = 0; i < 256; i++) inv_sub[SBOX[i]] = 8'(i);
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic key_sched_t expand(logic [127:0] k);
    key_sched_t w;
    logic [31:0] t;
    logic [7:0] rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i - 1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX[t[31:24]] ^ rc, SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i - 4] ^ t;
    end
    return w;
  endfunction

  function automatic plain_result_t decrypt_candidate(logic [IdxW-1:0] idx);
    plain_result_t res;
    key_sched_t w;
    logic [127:0] s, t;
    logic [7:0] a [4];
    w = expand({{key_prefix, idx[39:33]}, idx[32:1], {idx[0], KEY_W2_FILL[30:0]}, KEY_W3});
    s = {ct_high, ct_low} ^ {w[40], w[41], w[42], w[43]};
    for (int rnd = 9; rnd >= 0; rnd--) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8 * (4 * c + r) -: 8] = inv_sub[s[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8]];
      s = t ^ {w[4 * rnd], w[4 * rnd + 1], w[4 * rnd + 2], w[4 * rnd + 3]};
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[127 - 8 * (4 * c + r) -: 8];
          for (int r = 0; r < 4; r++)
            s[127 - 8 * (4 * c + r) -: 8] = gf_mul(a[r], 8'd14) ^
                gf_mul(a[(r + 1) % 4], 8'd11) ^ gf_mul(a[(r + 2) % 4], 8'd13) ^
                gf_mul(a[(r + 3) % 4], 8'd9);
        end
      end
    end
    res.idx = idx;
    res.ph = s[127:64];
    res.pl = s[63:0];
    // whole-word range compare, not per byte
    res.hit = s[127:96] >= RANGE_LO && s[127:96] <= RANGE_HI &&
              s[95:64] >= RANGE_LO && s[95:64] <= RANGE_HI &&
              s[63:32] == TAG_HI && s[31:0] == TAG_LO;
    return res;
  endfunction

  // Sample mid-cycle; handshakes complete at the next rising edge.
  always @(negedge clk_i) begin
    plain_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CT_HIGH: ct_high = cfg_data_i;
          CFG_CT_LOW:  ct_low = cfg_data_i;
          CFG_PREFIX:  key_prefix = cfg_data_i[PrefixW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) pending_results.push_back(decrypt_candidate(candidate_index_i));
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, index %h", $time, echo_index_i);
        end else begin
          want = pending_results.pop_front();
          if (match_i) match_count_o++;
          if (echo_index_i !== want.idx) begin
            fail_count_o++;
            $display("%0t: echo_index exp %h got %h", $time, want.idx, echo_index_i);
          end
          if (match_i !== want.hit) begin
            fail_count_o++;
            $display("%0t: match exp %b got %b (index %h)", $time, want.hit, match_i, want.idx);
          end
          if (plain_high_i !== want.ph) begin
            fail_count_o++;
            $display("%0t: plain_high exp %h got %h", $time, want.ph, plain_high_i);
          end
          if (plain_low_i !== want.pl) begin
            fail_count_o++;
            $display("%0t: plain_low exp %h got %h", $time, want.pl, plain_low_i);
          end
        end
      end
      pending_o = pending_results.size();
    end
  end

endmodule

[bench/tb.sv]
// Testbench top for the key search block: stimulus, config phases and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aks_pkg::*;

  typedef logic [43:0][31:0] key_sched_t;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [IdxW-1:0]     candidate_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [IdxW-1:0]     echo_index_o;
  logic                match_o;
  logic [63:0]         plain_high_o;
  logic [63:0]         plain_low_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  fail_count, pending, match_count;
  int                  items_sent, phases_run;
  int                  gap_mode, stall_mode, stall_left;

  aes128_key_search_check uut (.*);

  aks_result_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .candidate_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .echo_index_i(echo_index_o),
    .match_i(match_o), .plain_high_i(plain_high_o), .plain_low_i(plain_low_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .match_count_o(match_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

  // Mode 0: none, 1: light, 2: heavy; bursts mostly short, a few long.
  function automatic int idle_len(int mode);
    int r;
    r = $urandom_range(99);
    if (mode == 0) return 0;
    if (r >= (mode == 1 ? 12 : 40)) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= idle_len(stall_mode);
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  // Forward AES-128, used only to build ciphertexts that decrypt to chosen plaintexts.
  function automatic logic [127:0] encrypt_block(logic [PrefixW-1:0] prefix,
                                                 logic [IdxW-1:0] idx, logic [127:0] pt);
    key_sched_t w;
    logic [127:0] s, t;
    logic [31:0] tw;
    logic [7:0] rc;
    logic [7:0] a [4];
    rc = 8'h01;
    w[0] = {prefix, idx[39:33]};
    w[1] = idx[32:1];
    w[2] = {idx[0], KEY_W2_FILL[30:0]};
    w[3] = KEY_W3;
    for (int i = 4; i < 44; i++) begin
      tw = w[i - 1];
      if (i % 4 == 0) begin
        tw = {tw[23:0], tw[31:24]};
        tw = {SBOX[tw[31:24]] ^ rc, SBOX[tw[23:16]], SBOX[tw[15:8]], SBOX[tw[7:0]]};
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i - 4] ^ tw;
    end
    s = pt ^ {w[0], w[1], w[2], w[3]};
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      s = t;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[127 - 8 * (4 * c + r) -: 8];
          for (int r = 0; r < 4; r++)
            s[127 - 8 * (4 * c + r) -: 8] = gf_mul(a[r], 8'd2) ^
                gf_mul(a[(r + 1) % 4], 8'd3) ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
      end
      s ^= {w[4 * rnd], w[4 * rnd + 1], w[4 * rnd + 2], w[4 * rnd + 3]};
    end
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] in_range_word();
    return $urandom_range(RANGE_HI, RANGE_LO);
  endfunction

  task automatic send_item(logic [IdxW-1:0] idx);
    int gap;
    logic st;
    gap = idle_len(gap_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    candidate_index_i <= idx;
    forever begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
      if (!st) break;
    end
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [63:0] data);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    forever begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
    end
  endtask

  // Hold the sender until every result is back, then let the pipe drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(logic [63:0] ch, logic [63:0] cl, logic [63:0] prefix);
    write_reg(CFG_CT_HIGH, ch);
    write_reg(CFG_CT_LOW, cl);
    write_reg(CFG_PREFIX, prefix);
    cfg_valid_i <= 1'b0;
    phases_run++;
  endtask

  // Ciphertext chosen so that the hot index decrypts to pt; others hit it rarely.
  task automatic plain_phase(logic [127:0] pt, int n, int hot_pct);
    logic [PrefixW-1:0] prefix;
    logic [IdxW-1:0] hot;
    logic [127:0] ct;
    prefix = PrefixW'($urandom);
    hot = IdxW'(rand64());
    ct = encrypt_block(prefix, hot, pt);
    configure(ct[127:64], ct[63:0], (rand64() & ~64'h1ff_ffff) | {39'd0, prefix});
    send_item(hot);
    send_item(hot ^ 40'd1);
    for (int i = 2; i < n; i++)
      send_item($urandom_range(99) < hot_pct ? hot : IdxW'(rand64()));
    drain();
  endtask

  initial begin
    logic [127:0] pt;
    int kind;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    candidate_index_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    items_sent = 0;
    phases_run = 0;
    gap_mode = 0;
    stall_mode = 0;
    stall_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, index extremes.
    send_item('0);
    send_item('1);
    send_item(40'h1);
    send_item(40'h80_0000_0000);
    drain();

    // Unused register index must be ignored; oversized prefix keeps its low bits.
    write_reg(CfgNoReg, '1);
    configure('1, '1, '1);
    send_item('0);
    send_item('1);
    drain();

    // Range edges, whole-word compare, and tag mismatches.
    gap_mode = 1;
    stall_mode = 1;
    plain_phase({RANGE_LO, RANGE_HI, TAG_HI, TAG_LO}, 2, 0);
    plain_phase({RANGE_HI, RANGE_LO, TAG_HI, TAG_LO}, 2, 0);
    plain_phase({RANGE_LO - 32'd1, RANGE_LO, TAG_HI, TAG_LO}, 2, 0);
    plain_phase({RANGE_HI, RANGE_HI + 32'd1, TAG_HI, TAG_LO}, 2, 0);
    plain_phase({32'h41ff0000, 32'h5a00ffff, TAG_HI, TAG_LO}, 2, 0);
    plain_phase({RANGE_LO, RANGE_LO, TAG_HI, TAG_LO ^ 32'h1}, 2, 0);
    plain_phase({RANGE_LO, RANGE_LO, TAG_HI ^ 32'h8000_0000, TAG_LO}, 2, 0);

    for (int ph = 0; ph < 12; ph++) begin
      gap_mode = $urandom_range(2);
      stall_mode = $urandom_range(2);
      kind = (ph < 2) ? 1 : $urandom_range(2);
      if (kind == 2) begin
        pt = {in_range_word(), in_range_word(), TAG_HI, TAG_LO};
        if ($urandom_range(3) == 0) pt = {rand64(), rand64()};
        plain_phase(pt, 100, 30);
      end else begin
        if (kind == 1)
          configure(ph[0] ? '0 : '1, ph[0] ? '1 : '0, ph[0] ? '1 : '0);
        else
          configure(rand64(), rand64(), rand64());
        for (int i = 0; i < 100; i++) send_item(IdxW'(rand64()));
        drain();
      end
    end

    $display("Sent %0d candidates over %0d key/ciphertext settings; %0d matches flagged.",
             items_sent, phases_run, match_count);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[aes128_key_search_check.f]
hw/rtl/aks_pkg.sv
hw/rtl/aks_key_stage.sv
hw/rtl/aks_dec_stage.sv
hw/rtl/aes128_key_search_check.sv
bench/aks_result_checker.sv
bench/tb.sv
